// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the shortest path block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: rtl/dmsp_pkg.sv
// Package of the shortest path block: sizes, command codes and payload structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmsp_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_W       = 19;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int EADDR_W      = 2 * VIDX_W;
    localparam int EDGE_DEPTH   = MAX_VERTICES * MAX_VERTICES;
    localparam int CFG_W        = 4;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(8);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef struct packed {
        logic                   command;
        logic [2:0]             from_vertex;
        logic [2:0]             to_vertex;
        logic [WEIGHT_BITS-1:0] weight;
        logic [2:0]             source;
    } t_request;

    typedef struct packed {
        logic [2:0]        vertex;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/dmsp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dmsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/dijkstra_matrix_shortest_path.sv
// Top level of the shortest path block: command decoding, round sequencer, memories.
// Depends on dmsp_pkg, dmsp_ram and assert_macros.svh.
//
//   Channel   Signals                                Direction
//   request   start, busy, i_request                 in, accepted on start and not busy
//   result    o_result_valid, o_result               out, one result per vertex of a run
//   config    i_cfg_valid, o_cfg_ready, i_cfg_data   in, vertex count
//
// After reset all 64 entries of the edge memory are cleared with busy high.
// A load request writes the edge memory and leaves busy low.
// A run does a pick and a relax scan per round and then a result scan, with no
// relax when a picked vertex is unreachable; each scan is one read a cycle of the
// distance memory. Results follow one per cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module dijkstra_matrix_shortest_path
    import dmsp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_request         i_request,
    output logic                  o_result_valid,
    output t_result               o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_RELAX = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [CFG_W-1:0]        r_vcount, n_vcount;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [VIDX_W-1:0]       r_source, n_source;
    logic [CNT_W-1:0]        r_scan, n_scan;
    logic                    r_pv, n_pv;
    logic [VIDX_W-1:0]       r_pidx, n_pidx;
    logic [CNT_W-1:0]        r_round, n_round;
    logic [MAX_VERTICES-1:0] r_known, n_known;
    logic [MAX_VERTICES-1:0] r_finite, n_finite;
    logic                    r_fin_found, n_fin_found;
    logic [DIST_W-1:0]       r_fin_dist, n_fin_dist;
    logic [VIDX_W-1:0]       r_fin_idx, n_fin_idx;
    logic [VIDX_W-1:0]       r_last_unv, n_last_unv;
    logic [VIDX_W-1:0]       r_u, n_u;
    logic [DIST_W-1:0]       r_u_dist, n_u_dist;
    logic [EADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    logic [CNT_W-1:0]       active_n;
    logic                   accept;
    logic                   scan_issue;
    logic [VIDX_W-1:0]      scan_addr;
    logic                   phase_end;
    logic                   last_round;
    logic [VIDX_W-1:0]      chosen;
    logic [DIST_W-1:0]      cand;
    logic                   edge_we;
    logic [EADDR_W-1:0]     edge_waddr;
    logic [WEIGHT_BITS-1:0] edge_wdata;
    logic [WEIGHT_BITS-1:0] edge_rdata;
    logic                   dist_we;
    logic [VIDX_W-1:0]      dist_waddr;
    logic [DIST_W-1:0]      dist_wdata;
    logic [DIST_W-1:0]      dist_rdata;

    dmsp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr ({r_u, scan_addr}),
        .o_rdata (edge_rdata)
    );

    dmsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (scan_addr),
        .o_rdata (dist_rdata)
    );

    always_comb begin
        if (r_vcount == '0) begin
            active_n = CNT_W'(1);
        end else if (r_vcount > CFG_W'(MAX_VERTICES)) begin
            active_n = CNT_W'(MAX_VERTICES);
        end else begin
            active_n = CNT_W'(r_vcount);
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign scan_issue  = (r_scan < r_n);
    assign scan_addr   = r_scan[VIDX_W-1:0];
    assign phase_end   = r_pv && (r_pidx == VIDX_W'(r_n - CNT_W'(1)));
    assign last_round  = ((r_round + CNT_W'(1)) == (r_n - CNT_W'(1)));
    assign cand        = r_u_dist + DIST_W'(edge_rdata);

    assign edge_we    = (r_state == S_CLEAR) || (accept && i_request.command == CMD_LOAD);
    assign edge_waddr = (r_state == S_CLEAR) ? r_clr_addr
                                             : {i_request.from_vertex, i_request.to_vertex};
    assign edge_wdata = (r_state == S_CLEAR) ? '0 : i_request.weight;

    always_comb begin
        n_state     = r_state;
        n_vcount    = r_vcount;
        n_n         = r_n;
        n_source    = r_source;
        n_scan      = r_scan;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_round     = r_round;
        n_known     = r_known;
        n_finite    = r_finite;
        n_fin_found = r_fin_found;
        n_fin_dist  = r_fin_dist;
        n_fin_idx   = r_fin_idx;
        n_last_unv  = r_last_unv;
        n_u         = r_u;
        n_u_dist    = r_u_dist;
        n_clr_addr  = r_clr_addr;
        n_out_valid = 1'b0;
        n_out       = r_out;
        chosen      = r_last_unv;
        dist_we     = 1'b0;
        dist_waddr  = r_pidx;
        dist_wdata  = cand;

        if (i_cfg_valid) begin
            n_vcount = i_cfg_data;
        end

        if ((r_state == S_PICK || r_state == S_RELAX || r_state == S_OUT) && scan_issue) begin
            n_scan = r_scan + CNT_W'(1);
            n_pv   = 1'b1;
            n_pidx = scan_addr;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + EADDR_W'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_request.command == CMD_RUN) begin
                    n_n      = active_n;
                    n_source = i_request.source;
                    n_known  = '0;
                    n_finite = '0;
                    if (CNT_W'(i_request.source) < active_n) begin
                        n_finite[i_request.source] = 1'b1;
                    end
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                dist_we     = 1'b1;
                dist_waddr  = r_source;
                dist_wdata  = '0;
                n_round     = '0;
                n_scan      = '0;
                n_fin_found = 1'b0;
                n_state     = (r_n == CNT_W'(1)) ? S_OUT : S_PICK;
            end
            S_PICK: begin
                if (r_pv && !r_known[r_pidx]) begin
                    n_last_unv = r_pidx;
                    if (r_finite[r_pidx] && (!r_fin_found || dist_rdata <= r_fin_dist)) begin
                        n_fin_found = 1'b1;
                        n_fin_dist  = dist_rdata;
                        n_fin_idx   = r_pidx;
                    end
                end
                if (phase_end) begin
                    chosen          = n_fin_found ? n_fin_idx : n_last_unv;
                    n_u             = chosen;
                    n_u_dist        = n_fin_dist;
                    n_known[chosen] = 1'b1;
                    n_scan          = '0;
                    n_pv            = 1'b0;
                    if (n_fin_found) begin
                        n_state = S_RELAX;
                    end else begin
                        n_round     = r_round + CNT_W'(1);
                        n_fin_found = 1'b0;
                        n_state     = last_round ? S_OUT : S_PICK;
                    end
                end
            end
            S_RELAX: begin
                if (r_pv && !r_known[r_pidx] && edge_rdata != '0
                    && (!r_finite[r_pidx] || cand < dist_rdata)) begin
                    dist_we          = 1'b1;
                    n_finite[r_pidx] = 1'b1;
                end
                if (phase_end) begin
                    n_scan      = '0;
                    n_pv        = 1'b0;
                    n_round     = r_round + CNT_W'(1);
                    n_fin_found = 1'b0;
                    n_state     = last_round ? S_OUT : S_PICK;
                end
            end
            S_OUT: begin
                if (r_pv) begin
                    n_out_valid     = 1'b1;
                    n_out.vertex    = r_pidx;
                    n_out.distance  = r_finite[r_pidx] ? dist_rdata : '0;
                    n_out.reachable = r_finite[r_pidx];
                    n_out.last      = phase_end;
                end
                if (phase_end) begin
                    n_scan  = '0;
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_vcount    <= VCOUNT_RESET;
            r_scan      <= '0;
            r_pv        <= 1'b0;
            r_round     <= '0;
            r_known     <= '0;
            r_finite    <= '0;
            r_fin_found <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcount    <= n_vcount;
            r_scan      <= n_scan;
            r_pv        <= n_pv;
            r_round     <= n_round;
            r_known     <= n_known;
            r_finite    <= n_finite;
            r_fin_found <= n_fin_found;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_source   <= n_source;
        r_pidx     <= n_pidx;
        r_fin_dist <= n_fin_dist;
        r_fin_idx  <= n_fin_idx;
        r_last_unv <= n_last_unv;
        r_u        <= n_u;
        r_u_dist   <= n_u_dist;
        r_out      <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`include "assert_macros.svh"

    `ASSERT_CLK(a_last_ends_run, o_result_valid && o_result.last |=> !o_result_valid,
        "result follows the last result of a run")
    `ASSERT_NEVER(a_relax_known, dist_we && r_state == S_RELAX && r_known[dist_waddr],
        "distance of a visited vertex rewritten")
    `ASSERT_CLK(a_edge_write_idle, edge_we |-> (r_state == S_CLEAR || r_state == S_IDLE),
        "edge memory written during a run")
    `ASSERT_CLK(a_run_goes_busy, accept && i_request.command == CMD_RUN |=> busy,
        "accepted run request did not raise busy")

endmodule

`default_nettype wire
